>>> rtl/core/rtpv_pkg.sv
// Types and constants shared by the raw video packetizer modules.
// No dependencies; compile this file first.
`timescale 1ns / 1ps
`default_nettype none

package rtpv_pkg;

	// Item function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_SOURCE_ID    = 2'd0;
	localparam logic [1:0] CFG_FIRST_COLUMN = 2'd1;
	localparam logic [1:0] CFG_REGION_WIDTH = 2'd2;

	localparam logic [5:0] CFG_WIDTH_RESET = 6'd20;

	// Fixed header bytes: version 2, then marker set with payload type 96
	localparam logic [7:0] RTP_VER_BYTE = 8'h80;
	localparam logic [7:0] RTP_PT_BYTE  = {1'b1, 7'd96};

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [31:0] source_id;
		logic [14:0] first_column;
		logic [5:0]  width;       // already clipped to the maximum width
	} cfg_t;

	// One command from the front end to the word generator
	typedef struct packed {
		logic        hdr;   // 1: header run, 0: pixel word
		logic [31:0] data;  // timestamp for a header, pixel bytes otherwise
		logic [31:0] seq;   // sequence number at the time of the start
		logic        fin;   // this command completes the packet
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/rtpv_intf.sv
// Valid/ready channel interfaces for pixel input and packet word output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rtpv_pix_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] time_stamp;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	modport source(output valid, func, time_stamp, red, green, blue, input ready);
	modport sink(input valid, func, time_stamp, red, green, blue, output ready);
endinterface

interface rtpv_pkt_if;
	logic        valid;
	logic        ready;
	logic [31:0] packet_word;
	logic [2:0]  valid_bytes;
	logic        run_last;
	logic        packet_end;

	modport source(output valid, packet_word, valid_bytes, run_last, packet_end,
		input ready);
	modport sink(input valid, packet_word, valid_bytes, run_last, packet_end,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/rtpv_front.sv
// Front end: accepts items, tracks packet state and queues commands.
// Depends on rtpv_pkg and rtpv_intf.
`timescale 1ns / 1ps
`default_nettype none

module rtpv_front
	import rtpv_pkg::*;
#(
	parameter int LINES  = 10,
	parameter int LEFT_W = 9
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rtpv_pix_if.sink   pix,
	input  wire cfg_t  cfg,
	input  wire logic  q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic [31:0]       seq_q;
	logic [LEFT_W-1:0] left_q;
	logic              in_pkt_q;
	logic              accept;
	logic              is_start;
	logic              live;
	logic              empty;

	assign pix.ready = !q_full;
	assign accept    = pix.valid && pix.ready;
	assign is_start  = (pix.func == FUNC_START);
	assign live      = in_pkt_q && (left_q != '0);
	assign empty     = (cfg.width == 6'd0);

	always_comb begin
		q_push     = accept && (is_start || live);
		q_cmd.hdr  = is_start;
		q_cmd.data = is_start ? pix.time_stamp : {pix.red, pix.green, pix.blue, 8'h00};
		q_cmd.seq  = seq_q;
		q_cmd.fin  = is_start ? empty : (left_q == LEFT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= '0;
			left_q   <= '0;
			in_pkt_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				if (empty) begin
					// An empty region closes its packet with the header alone.
					seq_q    <= seq_q + 32'd1;
					left_q   <= '0;
					in_pkt_q <= 1'b0;
				end else begin
					left_q   <= LEFT_W'(LINES * cfg.width);
					in_pkt_q <= 1'b1;
				end
			end else if (!live) begin
				in_pkt_q <= 1'b0;
			end else begin
				left_q <= left_q - LEFT_W'(1);
				if (left_q == LEFT_W'(1)) begin
					in_pkt_q <= 1'b0;
					seq_q    <= seq_q + 32'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rtpv_fifo.sv
// Short command queue between the front end and the word generator.
// Depends on rtpv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtpv_fifo
	import rtpv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output cmd_t      head,
	output logic      full,
	output logic      empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("command pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from an empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/core/rtpv_back.sv
// Back end: expands queued commands into packet words behind an output register.
// Depends on rtpv_pkg and rtpv_intf.
`timescale 1ns / 1ps
`default_nettype none

module rtpv_back
	import rtpv_pkg::*;
#(
	parameter int LINES = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire cmd_t  q_head,
	input  wire logic  q_empty,
	output logic       q_pop,
	rtpv_pkt_if.source pkt
);

	localparam int HDR_BYTES  = 14 + 6 * LINES;
	localparam int HDR_WORDS  = (HDR_BYTES + 3) / 4;
	localparam int IW         = $clog2(HDR_WORDS);
	localparam int YW         = $clog2(LINES + 2);
	localparam logic [2:0] LAST_VALID = 3'(HDR_BYTES - 4 * (HDR_WORDS - 1));

	localparam logic [IW-1:0] W_BASE = IW'(0);
	localparam logic [IW-1:0] W_TS   = IW'(1);
	localparam logic [IW-1:0] W_SSRC = IW'(2);
	localparam logic [IW-1:0] W_EXT  = IW'(3);
	localparam logic [IW-1:0] W_LAST = IW'(HDR_WORDS - 1);

	logic [IW-1:0] widx_q;
	logic [YW-1:0] ly_q;     // line of the byte in lane two of the word
	logic [2:0]    ls_q;     // byte of that line header
	logic          out_valid_q;
	logic [31:0]   word_q;
	logic [2:0]    vbytes_q;
	logic          run_last_q;
	logic          pkt_end_q;

	logic          load;
	logic          hdr_last;
	logic [15:0]   len;
	logic [YW-1:0] ly_m1;
	logic [7:0]    b0, b1, b2, b3;
	logic [31:0]   hdr_word;
	logic [31:0]   word_d;
	logic [2:0]    vbytes_d;
	logic          run_last_d;
	logic          pkt_end_d;

	function automatic logic [7:0] line_byte(input logic [YW-1:0] y, input logic [2:0] sub,
		input logic [15:0] ln, input logic [14:0] fc);
		logic [7:0] r;
		logic       cont;
		cont = (y != YW'(LINES - 1));
		if (y >= YW'(LINES)) begin
			r = 8'h00;   // padding past the end of the header
		end else begin
			case (sub)
				3'd0:    r = ln[15:8];
				3'd1:    r = ln[7:0];
				3'd2:    r = 8'h00;
				3'd3:    r = 8'(y);
				3'd4:    r = {cont, fc[14:8]};
				3'd5:    r = fc[7:0];
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

	assign len      = 16'(cfg.width) * 16'd3;
	assign ly_m1    = ly_q - YW'(1);
	assign load     = !out_valid_q || pkt.ready;
	assign hdr_last = (widx_q == W_LAST);
	assign q_pop    = load && !q_empty && (!q_head.hdr || hdr_last);

	always_comb begin
		b2 = line_byte(ly_q, ls_q, len, cfg.first_column);
		b3 = line_byte(ly_q, ls_q + 3'd1, len, cfg.first_column);
		// The two leading lanes belong to the previous line when lane two opens a line.
		if (ls_q >= 3'd2) begin
			b0 = line_byte(ly_q, ls_q - 3'd2, len, cfg.first_column);
			b1 = line_byte(ly_q, ls_q - 3'd1, len, cfg.first_column);
		end else begin
			b0 = line_byte(ly_m1, 3'd4, len, cfg.first_column);
			b1 = line_byte(ly_m1, 3'd5, len, cfg.first_column);
		end
		case (widx_q)
			W_BASE:  hdr_word = {RTP_VER_BYTE, RTP_PT_BYTE, q_head.seq[15:0]};
			W_TS:    hdr_word = q_head.data;
			W_SSRC:  hdr_word = cfg.source_id;
			W_EXT:   hdr_word = {q_head.seq[31:16], b2, b3};
			default: hdr_word = {b0, b1, b2, b3};
		endcase
		if (q_head.hdr) begin
			word_d     = hdr_word;
			vbytes_d   = hdr_last ? LAST_VALID : 3'd4;
			run_last_d = hdr_last;
			pkt_end_d  = hdr_last && q_head.fin;
		end else begin
			word_d     = q_head.data;
			vbytes_d   = 3'd3;
			run_last_d = 1'b1;
			pkt_end_d  = q_head.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q      <= '0;
			ly_q        <= '0;
			ls_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty && q_head.hdr) begin
				if (hdr_last) begin
					widx_q <= '0;
					ly_q   <= '0;
					ls_q   <= '0;
				end else begin
					widx_q <= widx_q + IW'(1);
					if (widx_q >= W_EXT) begin
						// Each word moves four bytes through the six-byte line headers.
						case (ls_q)
							3'd0: begin
								ls_q <= 3'd4;
							end
							3'd2: begin
								ls_q <= 3'd0;
								ly_q <= ly_q + YW'(1);
							end
							default: begin
								ls_q <= 3'd2;
								ly_q <= ly_q + YW'(1);
							end
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q     <= word_d;
			vbytes_q   <= vbytes_d;
			run_last_q <= run_last_d;
			pkt_end_q  <= pkt_end_d;
		end
	end

	assign pkt.valid       = out_valid_q;
	assign pkt.packet_word = word_q;
	assign pkt.valid_bytes = vbytes_q;
	assign pkt.run_last    = run_last_q;
	assign pkt.packet_end  = pkt_end_q;

	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		widx_q <= W_LAST)
		else $error("header word index out of range");
	a_mid_header: assert property (@(posedge clk) disable iff (!arst_n)
		(widx_q != W_BASE) |-> (!q_empty && q_head.hdr))
		else $error("header run in progress without a header command");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(ls_q == 3'd0) || (ls_q == 3'd2) || (ls_q == 3'd4))
		else $error("line header byte phase out of step");

endmodule

`default_nettype wire

>>> rtl/core/rtp_raw_video_packetizer.sv
// Top level of the raw video RTP packetizer: configuration registers,
// front end, command queue and word generator.
// Depends on rtpv_pkg, rtpv_intf, rtpv_front, rtpv_fifo and rtpv_back.
//
//  channel  | dir | handshake        | contents
//  pix      | in  | valid / ready    | func, time_stamp, red, green, blue
//  pkt      | out | valid / ready    | packet_word, valid_bytes, run_last, packet_end
//  cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// A pixel item inside a packet becomes one output word; a start item becomes
// 14 + 6 * LINES bytes rounded up to words on the output (19 words at LINES = 10).
// A four-entry command queue lets the front end keep taking pixels while a header
// is still being sent. Reset clears the packet state, the queue and the output valid.
// A stall on pkt fills the queue, and only then drops pix.ready.
`timescale 1ns / 1ps
`default_nettype none

module rtp_raw_video_packetizer
	import rtpv_pkg::*;
#(
	parameter int LINES     = 10,
	parameter int MAX_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rtpv_pix_if.sink         pix,
	rtpv_pkt_if.source       pkt,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam logic [5:0] WCAP   = 6'((MAX_WIDTH > 63) ? 63 : MAX_WIDTH);
	localparam logic [5:0] W_RST  = (CFG_WIDTH_RESET > WCAP) ? WCAP : CFG_WIDTH_RESET;
	localparam int         LEFT_W = $clog2(LINES * int'(WCAP) + 1);

	cfg_t cfg_q;
	cmd_t q_cmd;
	cmd_t q_head;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_id    <= '0;
			cfg_q.first_column <= '0;
			cfg_q.width        <= W_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE_ID:    cfg_q.source_id <= cfg_data;
				CFG_FIRST_COLUMN: cfg_q.first_column <= cfg_data[14:0];
				CFG_REGION_WIDTH: begin
					// The width is clipped once here rather than at every use.
					cfg_q.width <= (cfg_data[5:0] > WCAP) ? WCAP : cfg_data[5:0];
				end
				default: ;
			endcase
		end
	end

	rtpv_front #(
		.LINES (LINES),
		.LEFT_W(LEFT_W)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix),
		.cfg   (cfg_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd (q_cmd)
	);

	rtpv_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_cmd),
		.pop   (q_pop),
		.head  (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	rtpv_back #(
		.LINES(LINES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_head (q_head),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.pkt    (pkt)
	);

endmodule

`default_nettype wire

>>> bench/rtp_raw_video_packetizer_tb.sv
// Self-checking testbench for the raw video RTP packetizer: drives start and pixel
// words, predicts every packet word and compares each one as it leaves the block.
// Depends on rtpv_pkg, the rtpv_pix_if / rtpv_pkt_if interfaces and the block.
`timescale 1ns / 1ps

module rtp_raw_video_packetizer_tb;
	import rtpv_pkg::*;

	localparam int LINES       = 10;
	localparam int MAX_WIDTH   = 32;
	localparam int HDR_BYTES   = 14 + 6 * LINES;
	localparam int HDR_WORDS   = (HDR_BYTES + 3) / 4;
	localparam int SETTLE      = 30;
	localparam int ITEM_TARGET = 440;
	localparam int TIMEOUT_NS  = 20_000_000;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		logic        fin;
	} pkt_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	rtpv_pix_if pix_ch();
	rtpv_pkt_if pkt_ch();

	rtp_raw_video_packetizer #(
		.LINES(LINES),
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.pkt(pkt_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor copy of the block's registers and packet state.
	logic [31:0] source_id;
	logic [14:0] first_column;
	logic [5:0]  region_width;
	logic [31:0] seq_count;
	int          pixels_left;
	bit          packet_open;

	pkt_word_t expected_words[$];

	int errors;
	int reported;
	int burst_left;
	int n_items;
	int productive_items;
	int n_headers;
	int n_pixel_words;
	int n_dropped;
	int n_packets;
	int n_settings;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d words still expected", expected_words.size());
		$display("status: fail");
		$finish;
	end

	// Works out the packet words that one accepted input word causes.
	task automatic predict_item(input logic fn, input logic [31:0] ts,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [7:0]  hb [0:HDR_WORDS*4-1];
		logic [15:0] len;
		logic [15:0] line_no;
		pkt_word_t   pw;
		int          w;
		int          n;
		int          rem;
		if (fn == FUNC_START) begin
			w = (region_width > MAX_WIDTH) ? MAX_WIDTH : int'(region_width);
			len = 16'(w * 3);
			for (int i = 0; i < HDR_WORDS * 4; i++)
				hb[i] = 8'h00;
			hb[0]  = RTP_VER_BYTE;
			hb[1]  = RTP_PT_BYTE;
			hb[2]  = seq_count[15:8];
			hb[3]  = seq_count[7:0];
			hb[4]  = ts[31:24];
			hb[5]  = ts[23:16];
			hb[6]  = ts[15:8];
			hb[7]  = ts[7:0];
			hb[8]  = source_id[31:24];
			hb[9]  = source_id[23:16];
			hb[10] = source_id[15:8];
			hb[11] = source_id[7:0];
			hb[12] = seq_count[31:24];
			hb[13] = seq_count[23:16];
			n = 14;
			for (int y = 0; y < LINES; y++) begin
				line_no = 16'(y);
				hb[n]     = len[15:8];
				hb[n + 1] = len[7:0];
				hb[n + 2] = line_no[15:8];
				hb[n + 3] = line_no[7:0];
				hb[n + 4] = {(y != LINES - 1), first_column[14:8]};
				hb[n + 5] = first_column[7:0];
				n += 6;
			end
			for (int i = 0; i < HDR_WORDS; i++) begin
				pw.word = {hb[4*i], hb[4*i + 1], hb[4*i + 2], hb[4*i + 3]};
				rem = HDR_BYTES - 4 * i;
				pw.nbytes = 3'((rem > 4) ? 4 : rem);
				pw.last = (i == HDR_WORDS - 1);
				pw.fin = pw.last && (w == 0);
				expected_words.push_back(pw);
			end
			n_headers++;
			productive_items++;
			// A zero width closes the packet on its own header.
			if (w == 0) begin
				seq_count = seq_count + 32'd1;
				pixels_left = 0;
				packet_open = 1'b0;
				n_packets++;
			end else begin
				pixels_left = LINES * w;
				packet_open = 1'b1;
			end
		end else begin
			if (!packet_open || pixels_left == 0) begin
				packet_open = 1'b0;
				n_dropped++;
			end else begin
				pw.word = {r, g, b, 8'h00};
				pw.nbytes = 3'd3;
				pw.last = 1'b1;
				pw.fin = (pixels_left == 1);
				expected_words.push_back(pw);
				pixels_left--;
				n_pixel_words++;
				productive_items++;
				if (pw.fin) begin
					packet_open = 1'b0;
					seq_count = seq_count + 32'd1;
					n_packets++;
				end
			end
		end
	endtask

	// Sends one input word; called and returns at a falling edge with valid low,
	// so a following send in the same burst raises it again at once.
	task automatic send_item(input logic fn, input logic [31:0] ts,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pix_ch.valid = 1'b1;
		pix_ch.func = fn;
		pix_ch.time_stamp = ts;
		pix_ch.red = r;
		pix_ch.green = g;
		pix_ch.blue = b;
		@(posedge clk);
		while (pix_ch.ready !== 1'b1)
			@(posedge clk);
		predict_item(fn, ts, r, g, b);
		n_items++;
		@(negedge clk);
		pix_ch.valid = 1'b0;
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_start();
		send_item(FUNC_START, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic send_pixel();
		send_item(FUNC_PIXEL, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_SOURCE_ID:    source_id = value;
			CFG_FIRST_COLUMN: first_column = value[14:0];
			CFG_REGION_WIDTH: region_width = value[5:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] src, input logic [14:0] col,
		input logic [5:0] width);
		write_reg(CFG_SOURCE_ID, src);
		write_reg(CFG_FIRST_COLUMN, {17'd0, col});
		write_reg(CFG_REGION_WIDTH, {26'd0, width});
		n_settings++;
	endtask

	// Dropped pixels leave nothing to wait for, so a settling pause follows.
	task automatic wait_idle();
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_pixel();
		send_start();
		repeat (3) send_pixel();
		wait_idle();
	endtask

	task automatic test_field_extremes();
		write_all(32'hFFFF_FFFF, 15'h7FFF, 6'd1);
		send_item(FUNC_START, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
		for (int i = 0; i < LINES; i++) begin
			if (i[0])
				send_item(FUNC_PIXEL, 32'h0000_0000, 8'h00, 8'h00, 8'h00);
			else
				send_item(FUNC_PIXEL, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
		end
		// The packet is complete, so this pixel is outside any packet.
		send_pixel();
		wait_idle();
	endtask

	task automatic test_zero_width();
		write_all(32'h0000_0000, 15'h0000, 6'd0);
		send_item(FUNC_START, 32'h0000_0000, 8'h00, 8'h00, 8'h00);
		send_pixel();
		wait_idle();
	endtask

	task automatic test_wide_and_restart();
		write_all($urandom, 15'($urandom), 6'd63);
		send_start();
		repeat (2) send_pixel();
		// A new start abandons the open packet without counting it.
		send_start();
		wait_idle();
		write_reg(CFG_REGION_WIDTH, 32'd33);
		send_start();
		send_pixel();
		wait_idle();
	endtask

	task automatic test_random_traffic();
		logic [31:0] src;
		logic [14:0] col;
		logic [5:0]  width;
		int          w;
		int          total;
		int          kind;
		while (n_items < ITEM_TARGET) begin
			wait_idle();
			case ($urandom_range(0, 3))
				0: src = 32'h0000_0000;
				1: src = 32'hFFFF_FFFF;
				default: src = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: col = 15'h0000;
				1: col = 15'h7FFF;
				default: col = 15'($urandom);
			endcase
			case ($urandom_range(0, 19))
				0: width = 6'd0;
				1: width = 6'd32;
				2: width = 6'($urandom_range(33, 63));
				3, 4: width = 6'($urandom_range(5, 8));
				default: width = 6'($urandom_range(1, 4));
			endcase
			write_all(src, col, width);
			w = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
			total = LINES * w;
			repeat ($urandom_range(1, 3)) begin
				kind = $urandom_range(0, 9);
				if (kind == 0)
					repeat ($urandom_range(1, 3)) send_pixel();
				send_start();
				if (w == 0 || w > 8)
					repeat ($urandom_range(0, 6)) send_pixel();
				else if (kind == 1)
					repeat ($urandom_range(0, total - 1)) send_pixel();
				else begin
					repeat (total) send_pixel();
					if ($urandom_range(0, 3) == 0)
						send_pixel();
				end
			end
		end
		wait_idle();
	endtask

	// Receiver: changes its stall pattern after each span of random length.
	initial begin
		int mode;
		int span;
		int run;
		pkt_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			while (span > 0) begin
				run = 1;
				case (mode)
					0: pkt_ch.ready = 1'b1;
					1: pkt_ch.ready = ($urandom_range(0, 3) != 0);
					2: begin
						pkt_ch.ready = ~pkt_ch.ready;
						run = pkt_ch.ready ? $urandom_range(1, 10) : $urandom_range(1, 20);
					end
					default: pkt_ch.ready = ~pkt_ch.ready;
				endcase
				repeat (run) @(negedge clk);
				span -= run;
			end
		end
	end

	// Checker: a word is captured at the rising edge and compared at the
	// following falling edge, after the sender has added its expectations.
	initial begin
		pkt_word_t got;
		pkt_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1) begin
				got.word = pkt_ch.packet_word;
				got.nbytes = pkt_ch.valid_bytes;
				got.last = pkt_ch.run_last;
				got.fin = pkt_ch.packet_end;
				@(negedge clk);
				if (expected_words.size() == 0) begin
					errors++;
					if (reported < REPORT_MAX) begin
						reported++;
						$display("unexpected word %h bytes %0d last %b end %b",
							got.word, got.nbytes, got.last, got.fin);
					end
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						errors++;
						if (reported < REPORT_MAX) begin
							reported++;
							$display("mismatch: expected word %h bytes %0d last %b end %b, got %h %0d %b %b",
								want.word, want.nbytes, want.last, want.fin,
								got.word, got.nbytes, got.last, got.fin);
						end
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SOURCE_ID;
		cfg_data = 32'd0;
		pix_ch.valid = 1'b0;
		pix_ch.func = FUNC_START;
		pix_ch.time_stamp = 32'd0;
		pix_ch.red = 8'd0;
		pix_ch.green = 8'd0;
		pix_ch.blue = 8'd0;
		source_id = 32'd0;
		first_column = 15'd0;
		region_width = CFG_WIDTH_RESET;
		seq_count = 32'd0;
		pixels_left = 0;
		packet_open = 1'b0;
		errors = 0;
		reported = 0;
		burst_left = 4;
		n_items = 0;
		productive_items = 0;
		n_headers = 0;
		n_pixel_words = 0;
		n_dropped = 0;
		n_packets = 0;
		n_settings = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE) @(negedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_zero_width();
		test_wide_and_restart();
		test_random_traffic();

		repeat (SETTLE) @(negedge clk);
		if (expected_words.size() != 0)
			errors++;
		$display("sent %0d input words, %0d of them producing output", n_items,
			productive_items);
		$display("covered %0d headers, %0d pixel words, %0d dropped pixels, %0d closed packets",
			n_headers, n_pixel_words, n_dropped, n_packets);
		$display("across %0d register settings with %0d errors", n_settings, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
rtl/core/rtpv_pkg.sv
rtl/core/rtpv_intf.sv
rtl/core/rtpv_front.sv
rtl/core/rtpv_fifo.sv
rtl/core/rtpv_back.sv
rtl/core/rtp_raw_video_packetizer.sv
bench/rtp_raw_video_packetizer_tb.sv
